// File: hdl/cotrb_pkg.sv
package cotrb_pkg;

    // default store depth
    localparam int DEPTH_DEFAULT = 1024;

    // field widths fixed by the interface
    localparam int STAMP_W = 64;
    localparam int SAMPLE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_OUT_W = 11;

    // Q16.16 start values for the running bounds
    localparam logic signed [SAMPLE_W-1:0] Q_ONE = 32'sd65536;
    localparam logic signed [SAMPLE_W-1:0] Q_MINUS_ONE = -32'sd65536;
    localparam logic signed [SAMPLE_W-1:0] Q_ZERO = 32'sd0;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic exec;    // accept the item on the ports and update state
        logic finish;  // load the result registers and raise the strobe
    } t_dp_cmd;

endpackage

// File: hdl/cotrb_ctrl.sv
module cotrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output cotrb_pkg::t_dp_cmd o_cmd
);

    cotrb_pkg::t_state r_state;
    cotrb_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cotrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cotrb_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = cotrb_pkg::ST_RESP;
                end
            end
            cotrb_pkg::ST_RESP: begin
                n_state = cotrb_pkg::ST_IDLE;
            end
            default: begin
                n_state = cotrb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy       = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            cotrb_pkg::ST_IDLE: begin
                o_cmd.exec = i_start;
            end
            cotrb_pkg::ST_RESP: begin
                o_busy       = 1'b1;
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/cotrb_datapath.sv
module cotrb_datapath #(
    parameter int DEPTH = cotrb_pkg::DEPTH_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cotrb_pkg::t_dp_cmd                      i_cmd,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_wdata,
    input  logic [1:0]                              i_command,
    input  logic [cotrb_pkg::STAMP_W-1:0]           i_cycle_stamp,
    input  logic signed [cotrb_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [cotrb_pkg::INDEX_W-1:0]           i_read_index,
    output logic                                    o_done,
    output logic                                    o_point_valid,
    output logic [cotrb_pkg::STAMP_W-1:0]           o_point_cycle,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_point_value,
    output logic                                    o_recorded,
    output logic [cotrb_pkg::COUNT_OUT_W-1:0]       o_stored_count,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_min_value,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_max_value
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > cotrb_pkg::INDEX_W) ? CW : cotrb_pkg::INDEX_W;
    localparam int EW = cotrb_pkg::STAMP_W + cotrb_pkg::SAMPLE_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [PW:0] DEPTH_SUM = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    // entry store: stamp in the upper bits, sample in the lower
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    // buffer state
    logic [PW-1:0]                          r_wr_ptr;
    logic [CW-1:0]                          r_count;
    logic signed [cotrb_pkg::SAMPLE_W-1:0]  r_prev;
    logic signed [cotrb_pkg::SAMPLE_W-1:0]  r_low;
    logic signed [cotrb_pkg::SAMPLE_W-1:0]  r_high;

    // per-item flags held until the result is loaded
    logic r_pt_valid;
    logic r_rec;
    logic r_done;

    cotrb_pkg::t_command cmd;
    logic                do_push;
    logic                do_clear;
    logic                rd_hit;
    logic                full;
    logic [PW-1:0]       idx_p;
    logic [PW:0]         rd_sum;
    logic [PW-1:0]       rd_addr;
    logic [PW-1:0]       n_wr_ptr;

    assign cmd  = cotrb_pkg::t_command'(i_command);
    assign full = (r_count == COUNT_FULL);

    // push is stored when empty or when the sample changed
    assign do_push  = i_cmd.exec && (cmd == cotrb_pkg::CMD_PUSH)
                      && ((r_count == '0) || (r_prev != i_sample_value));
    assign do_clear = i_cmd.exec && (cmd == cotrb_pkg::CMD_CLEAR);

    // read hit: age index below the count
    assign rd_hit = (cmd == cotrb_pkg::CMD_READ)
                    && (XW'(i_read_index) < XW'(r_count));

    // age index to slot: oldest sits at the write pointer once full
    assign idx_p  = PW'(i_read_index);
    assign rd_sum = {1'b0, r_wr_ptr} + {1'b0, idx_p};
    always_comb begin
        if (!full) begin
            rd_addr = idx_p;
        end else if (rd_sum >= DEPTH_SUM) begin
            rd_addr = PW'(rd_sum - DEPTH_SUM);
        end else begin
            rd_addr = rd_sum[PW-1:0];
        end
    end

    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= {i_cycle_stamp, i_sample_value};
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // buffer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_prev   <= cotrb_pkg::Q_ZERO;
            r_low    <= cotrb_pkg::Q_MINUS_ONE;
            r_high   <= cotrb_pkg::Q_ONE;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
                if (!full) begin
                    r_count <= r_count + 1'b1;
                end
                r_prev <= i_sample_value;
                if (i_sample_value < r_low) begin
                    r_low <= i_sample_value;
                end
                if (i_sample_value > r_high) begin
                    r_high <= i_sample_value;
                end
            end else if (do_clear) begin
                r_wr_ptr <= '0;
                r_count  <= '0;
                r_prev   <= cotrb_pkg::Q_ZERO;
            end
            // mode write reloads the bounds
            if (i_cfg_we) begin
                r_low  <= i_cfg_wdata ? cotrb_pkg::Q_ZERO : cotrb_pkg::Q_MINUS_ONE;
                r_high <= cotrb_pkg::Q_ONE;
            end
        end
    end

    // per-item flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pt_valid <= rd_hit;
            r_rec      <= do_push;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_point_valid  <= r_pt_valid;
            o_point_cycle  <= r_pt_valid ? r_rd_data[EW-1:cotrb_pkg::SAMPLE_W] : '0;
            o_point_value  <= r_pt_valid ? $signed(r_rd_data[cotrb_pkg::SAMPLE_W-1:0])
                                         : cotrb_pkg::Q_ZERO;
            o_recorded     <= r_rec;
            o_stored_count <= cotrb_pkg::COUNT_OUT_W'(r_count);
            o_min_value    <= r_low;
            o_max_value    <= r_high;
        end
    end

    assign o_done = r_done;

endmodule

// File: hdl/change_only_trace_ring_buffer_unit.sv
// Change-only trace buffer. An item is taken when i_start is high and o_busy is
// low; its result is registered in the response state and shown for exactly one
// cycle with o_done high; the receiver cannot hold it off. A push stores the stamp
// and sample only when the buffer is empty or the sample differs from the last
// stored one, overwriting the oldest entry when full; a read by age index (0 is
// oldest) returns the entry or an invalid zero point. The idle state updates state
// and addresses the entry store; the response state loads the registered read into
// the result registers; a new item can be taken in the cycle the previous result is
// shown. A mode write reloads the running minimum and maximum; clear keeps them.
module change_only_trace_ring_buffer_unit #(
    parameter int DEPTH = cotrb_pkg::DEPTH_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    output logic                                    o_done,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_wdata,
    input  logic [1:0]                              i_command,
    input  logic [cotrb_pkg::STAMP_W-1:0]           i_cycle_stamp,
    input  logic signed [cotrb_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [cotrb_pkg::INDEX_W-1:0]           i_read_index,
    output logic                                    o_point_valid,
    output logic [cotrb_pkg::STAMP_W-1:0]           o_point_cycle,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_point_value,
    output logic                                    o_recorded,
    output logic [cotrb_pkg::COUNT_OUT_W-1:0]       o_stored_count,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_min_value,
    output logic signed [cotrb_pkg::SAMPLE_W-1:0]   o_max_value
);

    cotrb_pkg::t_dp_cmd dp_cmd;

    // sequencing
    cotrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (dp_cmd)
    );

    // buffer state, entry store and result registers
    cotrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_command),
        .i_cycle_stamp  (i_cycle_stamp),
        .i_sample_value (i_sample_value),
        .i_read_index   (i_read_index),
        .o_done         (o_done),
        .o_point_valid  (o_point_valid),
        .o_point_cycle  (o_point_cycle),
        .o_point_value  (o_point_value),
        .o_recorded     (o_recorded),
        .o_stored_count (o_stored_count),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value)
    );

endmodule

// File: tb/change_only_trace_ring_buffer_unit_tb.sv
`timescale 1ns / 1ps

module change_only_trace_ring_buffer_unit_tb;

    localparam int DEPTH = cotrb_pkg::DEPTH_DEFAULT;
    localparam int NUM_DIRECTED = 22;
    localparam int CYCLE_LIMIT = 500000;

    // interface widths and Q16.16 constants
    localparam int STAMP_W = cotrb_pkg::STAMP_W;
    localparam int SAMPLE_W = cotrb_pkg::SAMPLE_W;
    localparam int INDEX_W = cotrb_pkg::INDEX_W;
    localparam int COUNT_OUT_W = cotrb_pkg::COUNT_OUT_W;
    localparam logic signed [SAMPLE_W-1:0] Q_ONE = cotrb_pkg::Q_ONE;
    localparam logic signed [SAMPLE_W-1:0] Q_MINUS_ONE = cotrb_pkg::Q_MINUS_ONE;
    localparam logic signed [SAMPLE_W-1:0] Q_ZERO = cotrb_pkg::Q_ZERO;

    // one result transfer
    typedef struct packed {
        logic                       valid;
        logic [STAMP_W-1:0]         cycle;
        logic signed [SAMPLE_W-1:0] value;
        logic                       recorded;
        logic [COUNT_OUT_W-1:0]     count;
        logic signed [SAMPLE_W-1:0] min_v;
        logic signed [SAMPLE_W-1:0] max_v;
    } t_point;

    // one directed item; fixed_exp set where the result is typed in
    typedef struct packed {
        cotrb_pkg::t_command        cmd;
        logic [STAMP_W-1:0]         stamp;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         index;
        logic                       fixed_exp;
        t_point                     exp_point;
    } t_row;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;
    localparam logic [STAMP_W-1:0] STAMP_ONES = {STAMP_W{1'b1}};

    localparam t_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // empty buffer straight after reset
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd0, Q_MINUS_ONE, Q_ONE}},
        '{cotrb_pkg::CMD_NOP, 64'd0, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd0, Q_MINUS_ONE, Q_ONE}},
        // first push always stored, a repeat is dropped
        '{cotrb_pkg::CMD_PUSH, 64'd0, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b1, 11'd1, Q_MINUS_ONE, Q_ONE}},
        '{cotrb_pkg::CMD_PUSH, 64'd1, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd1, Q_MINUS_ONE, Q_ONE}},
        // sample and stamp extremes move the bounds
        '{cotrb_pkg::CMD_PUSH, STAMP_ONES, S_MAX, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b1, 11'd2, Q_MINUS_ONE, S_MAX}},
        '{cotrb_pkg::CMD_PUSH, 64'd2, S_MIN, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b1, 11'd3, S_MIN, S_MAX}},
        // reads oldest first, then past the count
        '{cotrb_pkg::CMD_READ, 64'd9, 32'sd9, 10'd0, 1'b1,
          '{1'b1, 64'd0, 32'sd0, 1'b0, 11'd3, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd1, 1'b1,
          '{1'b1, STAMP_ONES, S_MAX, 1'b0, 11'd3, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd2, 1'b1,
          '{1'b1, 64'd2, S_MIN, 1'b0, 11'd3, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd3, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd3, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd1023, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd3, S_MIN, S_MAX}},
        // clear keeps the bounds
        '{cotrb_pkg::CMD_CLEAR, 64'd0, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd0, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_PUSH, 64'd5, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b1, 11'd1, S_MIN, S_MAX}},
        '{cotrb_pkg::CMD_PUSH, 64'd6, 32'sd0, 10'd0, 1'b1,
          '{1'b0, 64'd0, 32'sd0, 1'b0, 11'd1, S_MIN, S_MAX}},
        // remaining rows checked by the predictor
        '{cotrb_pkg::CMD_PUSH, 64'h5555_5555_5555_5555, -32'sd1, 10'h2AA, 1'b0, '0},
        '{cotrb_pkg::CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 32'sh0000FFFF, 10'h155, 1'b0, '0},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd2, 1'b0, '0},
        '{cotrb_pkg::CMD_NOP, STAMP_ONES, -32'sd1, 10'h3FF, 1'b0, '0},
        '{cotrb_pkg::CMD_CLEAR, STAMP_ONES, -32'sd1, 10'h3FF, 1'b0, '0},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd0, 1'b0, '0},
        '{cotrb_pkg::CMD_PUSH, 64'd7, 32'sh0000FFFF, 10'd0, 1'b0, '0},
        '{cotrb_pkg::CMD_READ, 64'd0, 32'sd0, 10'd0, 1'b0, '0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    logic                       o_done;
    logic                       i_cfg_we;
    logic                       i_cfg_wdata;
    logic [1:0]                 i_command;
    logic [STAMP_W-1:0]         i_cycle_stamp;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic [INDEX_W-1:0]         i_read_index;
    logic                       o_point_valid;
    logic [STAMP_W-1:0]         o_point_cycle;
    logic signed [SAMPLE_W-1:0] o_point_value;
    logic                       o_recorded;
    logic [COUNT_OUT_W-1:0]     o_stored_count;
    logic signed [SAMPLE_W-1:0] o_min_value;
    logic signed [SAMPLE_W-1:0] o_max_value;

    // predictor state
    logic [STAMP_W-1:0]         trace_stamps [DEPTH];
    logic signed [SAMPLE_W-1:0] trace_samples [DEPTH];
    logic [INDEX_W-1:0]         head_ptr;
    int unsigned                entries;
    logic signed [SAMPLE_W-1:0] last_sample;
    logic signed [SAMPLE_W-1:0] lowest;
    logic signed [SAMPLE_W-1:0] highest;

    t_point expected_points [$];
    int     fail_count;
    int     cycle_count;
    int     no_idle_left;

    change_only_trace_ring_buffer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_command),
        .i_cycle_stamp  (i_cycle_stamp),
        .i_sample_value (i_sample_value),
        .i_read_index   (i_read_index),
        .o_point_valid  (o_point_valid),
        .o_point_cycle  (o_point_cycle),
        .o_point_value  (o_point_value),
        .o_recorded     (o_recorded),
        .o_stored_count (o_stored_count),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // next trace point for one item; updates the predictor state
    function automatic t_point predict_trace_point(cotrb_pkg::t_command cmd,
                                                   logic [STAMP_W-1:0] stamp,
                                                   logic signed [SAMPLE_W-1:0] smp,
                                                   logic [INDEX_W-1:0] idx);
        t_point             pt;
        logic [INDEX_W-1:0] slot;
        pt = '0;
        case (cmd)
            cotrb_pkg::CMD_PUSH: begin
                if (entries == 0 || last_sample != smp) begin
                    trace_stamps[head_ptr] = stamp;
                    trace_samples[head_ptr] = smp;
                    head_ptr = head_ptr + 1'b1;
                    if (entries < DEPTH)
                        entries++;
                    last_sample = smp;
                    if (smp < lowest)
                        lowest = smp;
                    if (smp > highest)
                        highest = smp;
                    pt.recorded = 1'b1;
                end
            end
            cotrb_pkg::CMD_CLEAR: begin
                head_ptr = '0;
                entries = 0;
                last_sample = Q_ZERO;
            end
            cotrb_pkg::CMD_READ: begin
                if (idx < entries) begin
                    // once full, the oldest entry sits at the head
                    slot = (entries < DEPTH) ? idx : head_ptr + idx;
                    pt.valid = 1'b1;
                    pt.cycle = trace_stamps[slot];
                    pt.value = trace_samples[slot];
                end
            end
            default: ;
        endcase
        pt.count = entries[COUNT_OUT_W-1:0];
        pt.min_v = lowest;
        pt.max_v = highest;
        return pt;
    endfunction

    // drive one item after a random gap and wait until it is taken
    task automatic put_item(input cotrb_pkg::t_command cmd,
                            input logic [STAMP_W-1:0] stamp,
                            input logic signed [SAMPLE_W-1:0] smp,
                            input logic [INDEX_W-1:0] idx,
                            input logic fixed_exp, input t_point exp_point);
        int     gap;
        int     roll;
        t_point pt;
        gap = 0;
        if (no_idle_left > 0) begin
            no_idle_left--;
        end else begin
            roll = $urandom_range(99);
            if (roll < 4)
                no_idle_left = $urandom_range(80, 20);
            else if (roll < 40)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(3, 1);
            else if (roll < 97)
                gap = $urandom_range(10, 4);
            else
                gap = $urandom_range(60, 20);
        end
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_command = cmd;
        i_cycle_stamp = stamp;
        i_sample_value = smp;
        i_read_index = idx;
        do @(posedge i_clk); while (o_busy);
        pt = predict_trace_point(cmd, stamp, smp, idx);
        expected_points.push_back(fixed_exp ? exp_point : pt);
        @(negedge i_clk);
    endtask

    // mode write once the block has drained
    task automatic write_mode(input logic digital);
        i_start = 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = digital;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        lowest = digital ? Q_ZERO : Q_MINUS_ONE;
        highest = Q_ONE;
    endtask

    // random items; percentages pick the command mix and repeated samples
    task automatic run_phase(input int n_items, input int clear_pct, input int read_pct,
                             input int nop_pct, input int rep_pct);
        int                         roll;
        cotrb_pkg::t_command        cmd;
        logic signed [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0]         idx;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < clear_pct)
                cmd = cotrb_pkg::CMD_CLEAR;
            else if (roll < clear_pct + read_pct)
                cmd = cotrb_pkg::CMD_READ;
            else if (roll < clear_pct + read_pct + nop_pct)
                cmd = cotrb_pkg::CMD_NOP;
            else
                cmd = cotrb_pkg::CMD_PUSH;

            roll = $urandom_range(99);
            if (cmd == cotrb_pkg::CMD_PUSH && entries > 0 && roll < rep_pct) begin
                smp = last_sample;
            end else begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    case ($urandom_range(4))
                        0: smp = S_MIN;
                        1: smp = S_MAX;
                        2: smp = Q_ZERO;
                        3: smp = Q_ONE;
                        default: smp = Q_MINUS_ONE;
                    endcase
                end else if (roll < 50) begin
                    smp = $signed($urandom_range(6 * 65536)) - 32'sd196608;
                end else begin
                    smp = $urandom;
                end
            end

            if (entries > 0 && $urandom_range(99) < 70)
                idx = INDEX_W'($urandom_range(entries - 1));
            else
                idx = INDEX_W'($urandom_range(1023));

            put_item(cmd, {$urandom, $urandom}, smp, idx, 1'b0, '0);
        end
    endtask

    // result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_points.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                exp_pt = expected_points.pop_front();
                if (o_point_valid !== exp_pt.valid) begin
                    $error("point_valid: expected %0d, got %0d", exp_pt.valid, o_point_valid);
                    fail_count++;
                end
                if (o_point_cycle !== exp_pt.cycle) begin
                    $error("point_cycle: expected %0h, got %0h", exp_pt.cycle, o_point_cycle);
                    fail_count++;
                end
                if (o_point_value !== exp_pt.value) begin
                    $error("point_value: expected %0h, got %0h", exp_pt.value, o_point_value);
                    fail_count++;
                end
                if (o_recorded !== exp_pt.recorded) begin
                    $error("recorded: expected %0d, got %0d", exp_pt.recorded, o_recorded);
                    fail_count++;
                end
                if (o_stored_count !== exp_pt.count) begin
                    $error("stored_count: expected %0d, got %0d", exp_pt.count,
                           o_stored_count);
                    fail_count++;
                end
                if (o_min_value !== exp_pt.min_v) begin
                    $error("min_value: expected %0h, got %0h", exp_pt.min_v, o_min_value);
                    fail_count++;
                end
                if (o_max_value !== exp_pt.max_v) begin
                    $error("max_value: expected %0h, got %0h", exp_pt.max_v, o_max_value);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_command = cotrb_pkg::CMD_NOP;
        i_cycle_stamp = '0;
        i_sample_value = '0;
        i_read_index = '0;
        fail_count = 0;
        cycle_count = 0;
        no_idle_left = 0;
        head_ptr = '0;
        entries = 0;
        last_sample = Q_ZERO;
        lowest = Q_MINUS_ONE;
        highest = Q_ONE;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items, analog mode from reset
        for (int r = 0; r < NUM_DIRECTED; r++)
            put_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].stamp, DIRECTED_ROWS[r].sample,
                     DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].fixed_exp,
                     DIRECTED_ROWS[r].exp_point);

        // long push-heavy run without clears to fill and wrap the store
        write_mode(1'b1);
        run_phase(1450, 0, 8, 2, 10);
        // analog mode, frequent clears and reads
        write_mode(1'b0);
        run_phase(330, 4, 30, 5, 25);
        write_mode(1'b1);
        run_phase(150, 2, 25, 5, 20);

        i_start = 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/cotrb_pkg.sv
hdl/cotrb_ctrl.sv
hdl/cotrb_datapath.sv
hdl/change_only_trace_ring_buffer_unit.sv
tb/change_only_trace_ring_buffer_unit_tb.sv
